FILE: design/pbb_pkg.sv
// Shared types, constants and helpers for the particle box-bounce integrator.
`timescale 1ns / 1ps
package pbb_pkg;

   localparam int DIV_STEPS = 18;
   localparam int DIV_CNT_W = 5;

   localparam logic [1:0] REG_TIME_STEP     = 2'd0;
   localparam logic [1:0] REG_HALF_BOX_SIDE = 2'd1;
   localparam logic [1:0] REG_RESTITUTION   = 2'd2;
   localparam logic [1:0] REG_DAMP_ALL_AXES = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMUL,
      ST_SCHK,
      ST_SDIV,
      ST_SCMP,
      ST_DECIDE,
      ST_BMUL,
      ST_BPOS,
      ST_DMUL,
      ST_DVEL,
      ST_FMUL,
      ST_FPOS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

FILE: design/pbb_if.sv
// Handshake interfaces for the request, response and register write channels.
`timescale 1ns / 1ps
interface pbb_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface pbb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic [3:0]         bounce_count;
   logic               bounce_limit_hit;
   modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                   new_vel_z, bounce_count, bounce_limit_hit, input ready);
   modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                 new_vel_z, bounce_count, bounce_limit_hit, output ready);
endinterface

interface pbb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pbb_div.sv
// Radix-2 restoring divider: floor(dividend * 65536 / divisor), 18 quotient bits.
`timescale 1ns / 1ps
module pbb_div
   import pbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [17:0] quotient
);

   logic [32:0]          rem_ff, rem_in;
   logic [17:0]          shin_ff, shin_in;
   logic [17:0]          q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [32:0]          trial;
   logic                 take;

   assign trial = {rem_ff[31:0], shin_ff[17]};
   assign take  = trial >= {1'b0, req.divisor};

   always_comb begin
      rem_in  = rem_ff;
      shin_in = shin_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = {2'b00, req.dividend[32:2]};
         shin_in = {req.dividend[1:0], 16'h0000};
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = take ? (trial - {1'b0, req.divisor}) : trial;
         shin_in = {shin_ff[16:0], 1'b0};
         q_in    = {q_ff[16:0], take};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      shin_ff <= shin_in;
      q_ff    <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: design/particle_box_bounce_integrator.sv
// Top level: one-step particle integrator with box-wall reflections.
`timescale 1ns / 1ps
// Usage:
//   req_if carries one particle (position, velocity, Q16.16). csr_if writes the
//   step, half box side, restitution and damping mode; it is always ready and
//   must only be used while no request is in flight. rsp_if returns the new
//   position and velocity, the bounce count and the bounce-cap flag.
// Operation:
//   One particle at a time; req_if.ready is high only when idle. A single
//   32x18 multiplier and one divider are shared by all axes. Each pass scans
//   the three axes for the earliest wall crossing; a bounce moves every axis
//   to that time, puts the hit axis on the wall with its velocity negated and
//   scales velocity by the restitution (all axes or the hit axis only); the
//   final move uses the remaining step. MAX_BOUNCES bounds the bounces.
// Reset:
//   Synchronous, active high; the CSR registers return to their defaults and the
//   block goes idle with no response pending.
// Stall:
//   The response is held in place until rsp_if.ready; no new request is taken
//   until that transfer completes.
module particle_box_bounce_integrator
   import pbb_pkg::*;
#(
   parameter int MAX_BOUNCES = 8
) (
   input logic      clock,
   input logic      reset,
   pbb_req_if.sink  req_if,
   pbb_rsp_if.source rsp_if,
   pbb_csr_if.sink  csr_if
);

   localparam int CNT_W = $clog2(MAX_BOUNCES + 1);

   state_type state_ff, state_in;

   logic [16:0] time_step_ff;
   logic [30:0] hb_ff;
   logic [16:0] rest_ff;
   logic        damp_ff;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic               pos_wr, vel_wr;
   logic signed [31:0] pos_wd, vel_wd;

   logic [1:0]         axis_ff, axis_in;
   logic [1:0]         sel_ff, sel_in;
   logic               found_ff, found_in;
   logic               wneg_ff, wneg_in;
   logic               cwneg_ff, cwneg_in;
   logic [16:0]        tmin_ff, tmin_in;
   logic [16:0]        cand_ff, cand_in;
   logic [16:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               hit_ff, hit_in;
   logic signed [50:0] prod_ff, prod_in;

   logic signed [31:0] cur_pos, cur_vel;
   logic [17:0]        mul_b;
   logic signed [34:0] qm;
   logic signed [35:0] padd, hb36;
   logic               cross_hi, cross_lo;
   logic signed [31:0] wall32;
   logic signed [33:0] wall_gap;
   logic [32:0]        dmag;
   logic [31:0]        vmag;
   logic               zero_t, big_t;
   div_req_type        div_req;
   logic               div_start;
   logic               div_done;
   logic [17:0]        div_q;
   logic [CNT_W+3:0]   count_ext;

   assign cur_pos  = pos_ff[axis_ff];
   assign cur_vel  = vel_ff[axis_ff];
   assign qm       = prod_ff[50:16];
   assign padd     = 36'(cur_pos) + 36'(qm);
   assign hb36     = 36'($signed({1'b0, hb_ff}));
   assign cross_hi = padd > hb36;
   assign cross_lo = padd < -hb36;
   assign wall32   = cross_hi ? $signed({1'b0, hb_ff}) : -$signed({1'b0, hb_ff});
   assign wall_gap = 34'(wall32) - 34'(cur_pos);
   assign dmag     = wall_gap[33] ? 33'(-wall_gap) : wall_gap[32:0];
   assign vmag     = cur_vel[31] ? (~cur_vel + 32'd1) : cur_vel;
   assign zero_t   = (cur_vel == 32'sd0) || (wall_gap == 34'sd0) ||
                     (wall_gap[33] != cur_vel[31]);
   assign big_t    = {1'b0, dmag} >= {vmag, 2'b00};

   assign div_req = {div_start, dmag, vmag};

   pbb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      unique case (state_ff)
         ST_SMUL, ST_FMUL: mul_b = {1'b0, rem_ff};
         ST_BMUL:          mul_b = {1'b0, tmin_ff};
         default:          mul_b = {1'b0, rest_ff};
      endcase
   end
   assign prod_in = 51'(cur_vel) * 51'($signed({1'b0, mul_b}));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_if.valid) state_in = ST_SMUL;
         ST_SMUL:   state_in = ST_SCHK;
         ST_SCHK: begin
            if (cross_hi || cross_lo) begin
               state_in = (zero_t || big_t) ? ST_SCMP : ST_SDIV;
            end else begin
               state_in = (axis_ff == 2'd2) ? ST_DECIDE : ST_SMUL;
            end
         end
         ST_SDIV:   if (div_done) state_in = ST_SCMP;
         ST_SCMP:   state_in = (axis_ff == 2'd2) ? ST_DECIDE : ST_SMUL;
         ST_DECIDE: begin
            if (found_ff && (32'(count_ff) < MAX_BOUNCES)) state_in = ST_BMUL;
            else state_in = ST_FMUL;
         end
         ST_BMUL:   state_in = ST_BPOS;
         ST_BPOS:   state_in = (axis_ff == 2'd2) ? ST_DMUL : ST_BMUL;
         ST_DMUL:   state_in = ST_DVEL;
         ST_DVEL:   state_in = (damp_ff && axis_ff != 2'd2) ? ST_DMUL : ST_SMUL;
         ST_FMUL:   state_in = ST_FPOS;
         ST_FPOS:   state_in = (axis_ff == 2'd2) ? ST_DONE : ST_FMUL;
         ST_DONE:   if (rsp_if.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      axis_in   = axis_ff;
      sel_in    = sel_ff;
      found_in  = found_ff;
      wneg_in   = wneg_ff;
      cwneg_in  = cwneg_ff;
      tmin_in   = tmin_ff;
      cand_in   = cand_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      hit_in    = hit_ff;
      pos_wr    = 1'b0;
      vel_wr    = 1'b0;
      pos_wd    = cur_pos;
      vel_wd    = cur_vel;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            axis_in  = 2'd0;
            found_in = 1'b0;
            rem_in   = time_step_ff;
            count_in = '0;
            hit_in   = 1'b0;
         end
         ST_SCHK: begin
            cwneg_in = !cross_hi;
            if (cross_hi || cross_lo) begin
               if (zero_t) cand_in = 17'd0;
               else if (big_t) cand_in = rem_ff;
               else div_start = 1'b1;
            end else if (axis_ff != 2'd2) begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_SDIV: begin
            if (div_done) cand_in = (div_q > {1'b0, rem_ff}) ? rem_ff : div_q[16:0];
         end
         ST_SCMP: begin
            if (!found_ff || cand_ff < tmin_ff) begin
               found_in = 1'b1;
               sel_in   = axis_ff;
               tmin_in  = cand_ff;
               wneg_in  = cwneg_ff;
            end
            if (axis_ff != 2'd2) axis_in = axis_ff + 2'd1;
         end
         ST_DECIDE: begin
            axis_in = 2'd0;
            if (found_ff && (32'(count_ff) >= MAX_BOUNCES)) hit_in = 1'b1;
         end
         ST_BPOS: begin
            pos_wr = 1'b1;
            if (axis_ff == sel_ff) begin
               pos_wd = wneg_ff ? -$signed({1'b0, hb_ff}) : $signed({1'b0, hb_ff});
               vel_wr = 1'b1;
               vel_wd = sat32(-36'(cur_vel));
            end else begin
               pos_wd = sat32(padd);
            end
            if (axis_ff == 2'd2) axis_in = damp_ff ? 2'd0 : sel_ff;
            else axis_in = axis_ff + 2'd1;
         end
         ST_DVEL: begin
            vel_wr = 1'b1;
            vel_wd = sat32(36'(qm));
            if (damp_ff && axis_ff != 2'd2) begin
               axis_in = axis_ff + 2'd1;
            end else begin
               axis_in  = 2'd0;
               rem_in   = rem_ff - tmin_ff;
               count_in = count_ff + 1'b1;
               found_in = 1'b0;
            end
         end
         ST_FPOS: begin
            pos_wr = 1'b1;
            if (hit_ff && padd > hb36) pos_wd = $signed({1'b0, hb_ff});
            else if (hit_ff && padd < -hb36) pos_wd = -$signed({1'b0, hb_ff});
            else pos_wd = sat32(padd);
            if (axis_ff != 2'd2) axis_in = axis_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_step_ff <= 17'd655;
         hb_ff        <= 31'd131072;
         rest_ff      <= 17'd52429;
         damp_ff      <= 1'b1;
         axis_ff      <= 2'd0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         found_ff <= found_in;
         count_ff <= count_in;
         hit_ff   <= hit_in;
         if (csr_if.valid) begin
            unique case (csr_if.index)
               REG_TIME_STEP:     time_step_ff <= csr_if.data[16:0];
               REG_HALF_BOX_SIDE: hb_ff        <= csr_if.data[30:0];
               REG_RESTITUTION:   rest_ff      <= csr_if.data[16:0];
               REG_DAMP_ALL_AXES: damp_ff      <= csr_if.data[0];
               default: begin
               end
            endcase
         end
      end
      sel_ff   <= sel_in;
      wneg_ff  <= wneg_in;
      cwneg_ff <= cwneg_in;
      tmin_ff  <= tmin_in;
      cand_ff  <= cand_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      if (state_ff == ST_IDLE && req_if.valid) begin
         pos_ff[0] <= req_if.pos_x;
         pos_ff[1] <= req_if.pos_y;
         pos_ff[2] <= req_if.pos_z;
         vel_ff[0] <= req_if.vel_x;
         vel_ff[1] <= req_if.vel_y;
         vel_ff[2] <= req_if.vel_z;
      end else begin
         if (pos_wr) pos_ff[axis_ff] <= pos_wd;
         if (vel_wr) vel_ff[axis_ff] <= vel_wd;
      end
   end

   assign count_ext = {4'b0000, count_ff};

   assign csr_if.ready            = 1'b1;
   assign req_if.ready            = (state_ff == ST_IDLE);
   assign rsp_if.valid            = (state_ff == ST_DONE);
   assign rsp_if.new_pos_x        = pos_ff[0];
   assign rsp_if.new_pos_y        = pos_ff[1];
   assign rsp_if.new_pos_z        = pos_ff[2];
   assign rsp_if.new_vel_x        = vel_ff[0];
   assign rsp_if.new_vel_y        = vel_ff[1];
   assign rsp_if.new_vel_z        = vel_ff[2];
   assign rsp_if.bounce_count     = count_ext[3:0];
   assign rsp_if.bounce_limit_hit = hit_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_BOUNCES)
      else $error("bounce count above cap");

   a_hit_at_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && hit_ff) |-> (32'(count_ff) == MAX_BOUNCES))
      else $error("limit flag without reaching cap");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> (cand_ff <= rem_ff))
      else $error("crossing time beyond remaining time");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while response pending");

endmodule
